[design/sbb_pkg.sv]
package sbb_pkg;

  // fixed field widths
  localparam int ADDR_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 8;
  localparam int SINE_DEPTH = 256;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register reset values
  localparam logic [1:0] CHAN_EN_RST       = 2'd3;
  localparam logic       BLOCK_MODE_RST    = 1'b1;
  localparam logic [7:0] BLOCK_SAMPLES_RST = 8'd128;
  localparam logic [7:0] PAGE_LIMIT_RST    = 8'd0;
  localparam logic       WAVE_EN_RST       = 1'b0;
  localparam logic [7:0] PHASE_STEP_RST    = 8'd1;
  localparam logic [7:0] WAVE_AMP_RST      = 8'd255;
  localparam logic [7:0] WAVE_OFFSET_RST   = 8'd0;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_START    = 2'd1,
    CMD_CONSUMED = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_DAC    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAN_EN       = 3'd0,
    REG_BLOCK_MODE    = 3'd1,
    REG_BLOCK_SAMPLES = 3'd2,
    REG_PAGE_LIMIT    = 3'd3,
    REG_WAVE_EN       = 3'd4,
    REG_PHASE_STEP    = 3'd5,
    REG_WAVE_AMP      = 3'd6,
    REG_WAVE_OFFSET   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         chan_en;
    logic               block_mode;
    logic [7:0]         block_samples;
    logic [7:0]         page_limit;
    logic               wave_en;
    logic [PHASE_W-1:0] phase_step;
    logic [7:0]         wave_amp;
    logic [7:0]         wave_offset;
  } cfg_t;

  // everything one item produces, apart from the dac value
  typedef struct packed {
    logic [1:0]          n_words;
    logic [ADDR_W-1:0]   word0_addr;
    logic [SAMPLE_W-1:0] word0_data;
    logic [ADDR_W-1:0]   word1_addr;
    logic [SAMPLE_W-1:0] word1_data;
    logic                dac_en;
    logic [ADDR_W-1:0]   status_addr;
    logic [7:0]          blocks_ready;
    logic                running;
  } rec_t;

  // one period of sine, offset binary
  localparam logic [7:0] SINE_TAB [SINE_DEPTH] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd144, 8'd147, 8'd150,
    8'd153, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
    8'd177, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
    8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd239, 8'd240, 8'd241, 8'd243, 8'd244,
    8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
    8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
    8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
    8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd239, 8'd237, 8'd235,
    8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
    8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
    8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
    8'd177, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
    8'd153, 8'd150, 8'd147, 8'd144, 8'd140, 8'd137, 8'd134, 8'd131,
    8'd128, 8'd125, 8'd122, 8'd119, 8'd116, 8'd112, 8'd109, 8'd106,
    8'd103, 8'd100, 8'd97,  8'd94,  8'd91,  8'd88,  8'd85,  8'd82,
    8'd79,  8'd77,  8'd74,  8'd71,  8'd68,  8'd65,  8'd63,  8'd60,
    8'd57,  8'd55,  8'd52,  8'd50,  8'd47,  8'd45,  8'd43,  8'd40,
    8'd38,  8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd26,  8'd24,
    8'd22,  8'd21,  8'd19,  8'd17,  8'd16,  8'd15,  8'd13,  8'd12,
    8'd11,  8'd10,  8'd8,   8'd7,   8'd6,   8'd6,   8'd5,   8'd4,
    8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,
    8'd3,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,   8'd10,
    8'd11,  8'd12,  8'd13,  8'd15,  8'd16,  8'd17,  8'd19,  8'd21,
    8'd22,  8'd24,  8'd26,  8'd28,  8'd30,  8'd32,  8'd34,  8'd36,
    8'd38,  8'd40,  8'd43,  8'd45,  8'd47,  8'd50,  8'd52,  8'd55,
    8'd57,  8'd60,  8'd63,  8'd65,  8'd68,  8'd71,  8'd74,  8'd77,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd116, 8'd119, 8'd122, 8'd125
  };

endpackage

[design/sbb_if.sv]
// command channel
interface sbb_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [sbb_pkg::SAMPLE_W-1:0]  sample_zero;
  logic [sbb_pkg::SAMPLE_W-1:0]  sample_one;

  modport source (output valid, command, sample_zero, sample_one, input ready);
  modport sink   (input valid, command, sample_zero, sample_one, output ready);
endinterface

// result channel
interface sbb_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [sbb_pkg::ADDR_W-1:0]    address;
  logic [sbb_pkg::SAMPLE_W-1:0]  data;
  logic [7:0]                    blocks_ready;
  logic                          running;
  logic                          last;

  modport source (output valid, kind, address, data, blocks_ready, running, last,
                  input ready);
  modport sink   (input valid, kind, address, data, blocks_ready, running, last,
                  output ready);
endinterface

[design/sbb_sine_rom.sv]
module sbb_sine_rom (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sbb_pkg::PHASE_W-1:0] addr_i,
  output logic [7:0]                  data_o
);

  logic [7:0] data_q;

  // synchronous read, registered output
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= sbb_pkg::SINE_TAB[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

[design/sbb_core.sv]
module sbb_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbb_pkg::cfg_t                cfg_i,
  sbb_in_if.sink                       in_i,
  input  logic                         rec_take_i,
  output logic                         rec_valid_o,
  output sbb_pkg::rec_t                rec_o,
  output logic                         rom_en_o,
  output logic [sbb_pkg::PHASE_W-1:0]  rom_addr_o
);

  logic [sbb_pkg::ADDR_W-1:0]  ptr_q, ptr_d, ptr_tick;
  logic [7:0]                  left_q, left_d, left_tick;
  logic [7:0]                  rdy_q, rdy_d;
  logic                        active_q, active_d;
  logic [sbb_pkg::PHASE_W-1:0] phase_q, phase_d, phase_tick;
  logic                        rec_valid_q, rec_valid_d;
  sbb_pkg::rec_t               rec_q, rec_d;
  logic                        fire, tick;
  logic [1:0]                  nw;

  // stage slot frees when the output side takes it
  assign in_i.ready = !rec_valid_q || rec_take_i;
  assign fire       = in_i.valid && in_i.ready;
  assign tick       = (sbb_pkg::cmd_e'(in_i.command) == sbb_pkg::CMD_TICK) && active_q;

  // per-tick arithmetic
  assign nw         = {1'b0, cfg_i.chan_en[0]} + {1'b0, cfg_i.chan_en[1]};
  assign ptr_tick   = ptr_q + sbb_pkg::ADDR_W'({nw, 1'b0});
  assign left_tick  = left_q - 8'(nw);
  assign phase_tick = phase_q + cfg_i.phase_step;

  // state update
  always_comb begin
    ptr_d    = ptr_q;
    left_d   = left_q;
    rdy_d    = rdy_q;
    active_d = active_q;
    phase_d  = phase_q;
    case (sbb_pkg::cmd_e'(in_i.command))
      sbb_pkg::CMD_TICK: begin
        if (active_q) begin
          ptr_d  = ptr_tick;
          left_d = left_tick;
          if (cfg_i.block_mode) begin
            if (left_tick == 8'd0) begin
              rdy_d  = rdy_q + 8'd1;
              left_d = cfg_i.block_samples;
            end
          end else if (ptr_tick[sbb_pkg::ADDR_W-1 -: 8] >= cfg_i.page_limit) begin
            active_d = 1'b0;
          end
          if (cfg_i.wave_en) begin
            phase_d = phase_tick;
          end
        end
      end
      sbb_pkg::CMD_START: begin
        ptr_d    = '0;
        left_d   = cfg_i.block_samples;
        rdy_d    = 8'd0;
        phase_d  = '0;
        active_d = 1'b1;
      end
      sbb_pkg::CMD_CONSUMED: begin
        if (rdy_q != 8'd0) begin
          rdy_d = rdy_q - 8'd1;
        end
      end
      sbb_pkg::CMD_STOP: begin
        active_d = 1'b0;
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  // result record of this item
  always_comb begin
    rec_d.n_words      = tick ? nw : 2'd0;
    rec_d.word0_addr   = ptr_q;
    rec_d.word0_data   = cfg_i.chan_en[0] ? in_i.sample_one : in_i.sample_zero;
    rec_d.word1_addr   = ptr_q + sbb_pkg::ADDR_W'(2);
    rec_d.word1_data   = in_i.sample_zero;
    rec_d.dac_en       = tick && cfg_i.wave_en;
    rec_d.status_addr  = ptr_d;
    rec_d.blocks_ready = rdy_d;
    rec_d.running      = active_d;
  end

  assign rec_valid_d = fire ? 1'b1 : (rec_take_i ? 1'b0 : rec_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      left_q      <= 8'd0;
      rdy_q       <= 8'd0;
      active_q    <= 1'b0;
      phase_q     <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      rec_valid_q <= rec_valid_d;
      if (fire) begin
        ptr_q    <= ptr_d;
        left_q   <= left_d;
        rdy_q    <= rdy_d;
        active_q <= active_d;
        phase_q  <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rec_q <= rec_d;
    end
  end

  // sine lookup runs alongside the record
  assign rom_en_o    = fire && tick && cfg_i.wave_en;
  assign rom_addr_o  = phase_tick;
  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

[design/sbb_out.sv]
module sbb_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbb_pkg::cfg_t cfg_i,
  input  logic          rec_valid_i,
  input  sbb_pkg::rec_t rec_i,
  input  logic [7:0]    rom_data_i,
  output logic          rec_take_o,
  sbb_out_if.source     out_o
);

  logic          b_valid_q, b_valid_d;
  sbb_pkg::rec_t b_rec_q;
  logic [7:0]    dac_q, dac_d;
  logic [1:0]    idx_q, idx_d;
  logic [1:0]    last_idx;
  logic [15:0]   prod;
  logic          is_last, out_fire, done, take;

  // item boundaries
  assign last_idx = b_rec_q.n_words + {1'b0, b_rec_q.dac_en};
  assign is_last  = idx_q == last_idx;
  assign out_fire = out_o.valid && out_o.ready;
  assign done     = out_fire && is_last;
  assign take     = rec_valid_i && (!b_valid_q || done);

  // scale and offset the sine sample
  assign prod  = rom_data_i * cfg_i.wave_amp;
  assign dac_d = prod[15:8] + cfg_i.wave_offset;

  always_comb begin
    b_valid_d = b_valid_q;
    idx_d     = idx_q;
    if (take) begin
      b_valid_d = 1'b1;
      idx_d     = 2'd0;
    end else if (done) begin
      b_valid_d = 1'b0;
      idx_d     = 2'd0;
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      b_valid_q <= b_valid_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      b_rec_q <= rec_i;
      dac_q   <= dac_d;
    end
  end

  // pick the beat for the current index
  always_comb begin
    if (idx_q < b_rec_q.n_words) begin
      out_o.kind    = sbb_pkg::KIND_WORD;
      out_o.address = (idx_q == 2'd0) ? b_rec_q.word0_addr : b_rec_q.word1_addr;
      out_o.data    = (idx_q == 2'd0) ? b_rec_q.word0_data : b_rec_q.word1_data;
    end else if (b_rec_q.dac_en && (idx_q == b_rec_q.n_words)) begin
      out_o.kind    = sbb_pkg::KIND_DAC;
      out_o.address = '0;
      out_o.data    = {8'd0, dac_q};
    end else begin
      out_o.kind    = sbb_pkg::KIND_STATUS;
      out_o.address = b_rec_q.status_addr;
      out_o.data    = '0;
    end
  end

  assign out_o.valid        = b_valid_q;
  assign out_o.blocks_ready = b_rec_q.blocks_ready;
  assign out_o.running      = b_rec_q.running;
  assign out_o.last         = is_last;
  assign rec_take_o         = take;

endmodule

[design/sample_block_buffer_with_dds.sv]
// Sample block buffer with sine generator.
// in_i carries commands (sample tick, start, block consumed, stop) with the
// two converter samples; out_o carries result beats: memory word writes,
// a dac update and one status beat that closes every item (last set).
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while idle; the block itself does not enforce it. A
// tick while running gives up to four beats: the enabled sample words, the
// dac update when the generator is on, then status. Any other item gives
// status alone. An item is registered in the core record, then in the output
// buffer that presents its beats; the sine rom read and the amplitude
// multiply sit between the two stages. One beat per cycle while the receiver
// is ready; an item's one to four beats leave in turn through the single
// output port. One item waits in the first stage while the previous one
// drains, so one more item is accepted while a beat is stalled at the
// output. Reset clears the state and loads register defaults; no clearing
// pass. When the receiver stalls, the beat holds and the input fills one slot.
module sample_block_buffer_with_dds (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sbb_in_if.sink                         in_i,
  sbb_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sbb_pkg::cfg_t               cfg_q, cfg_d;
  sbb_pkg::rec_t               rec;
  logic                        rec_valid, rec_take;
  logic                        rom_en;
  logic [sbb_pkg::PHASE_W-1:0] rom_addr;
  logic [7:0]                  rom_data;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sbb_pkg::reg_idx_e'(cfg_idx_i))
        sbb_pkg::REG_CHAN_EN:       cfg_d.chan_en       = cfg_data_i[1:0];
        sbb_pkg::REG_BLOCK_MODE:    cfg_d.block_mode    = cfg_data_i[0];
        sbb_pkg::REG_BLOCK_SAMPLES: cfg_d.block_samples = cfg_data_i;
        sbb_pkg::REG_PAGE_LIMIT:    cfg_d.page_limit    = cfg_data_i;
        sbb_pkg::REG_WAVE_EN:       cfg_d.wave_en       = cfg_data_i[0];
        sbb_pkg::REG_PHASE_STEP:    cfg_d.phase_step    = cfg_data_i;
        sbb_pkg::REG_WAVE_AMP:      cfg_d.wave_amp      = cfg_data_i;
        sbb_pkg::REG_WAVE_OFFSET:   cfg_d.wave_offset   = cfg_data_i;
        default:                    cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_en       <= sbb_pkg::CHAN_EN_RST;
      cfg_q.block_mode    <= sbb_pkg::BLOCK_MODE_RST;
      cfg_q.block_samples <= sbb_pkg::BLOCK_SAMPLES_RST;
      cfg_q.page_limit    <= sbb_pkg::PAGE_LIMIT_RST;
      cfg_q.wave_en       <= sbb_pkg::WAVE_EN_RST;
      cfg_q.phase_step    <= sbb_pkg::PHASE_STEP_RST;
      cfg_q.wave_amp      <= sbb_pkg::WAVE_AMP_RST;
      cfg_q.wave_offset   <= sbb_pkg::WAVE_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // state update and item record
  sbb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .rec_take_i  (rec_take),
    .rec_valid_o (rec_valid),
    .rec_o       (rec),
    .rom_en_o    (rom_en),
    .rom_addr_o  (rom_addr)
  );

  // sine table
  sbb_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // dac scaling and beat sequencing
  sbb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (rec_valid),
    .rec_i       (rec),
    .rom_data_i  (rom_data),
    .rec_take_o  (rec_take),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  // an item always closes with its status beat
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.kind == sbb_pkg::KIND_STATUS)
    else $error("final beat of an item is not a status beat");

  // beats of one item follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=> out_o.valid)
    else $error("item broken off before its final beat");

  // a start leaves a running record with the pointer cleared
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.command == sbb_pkg::CMD_START
    |=> rec_valid && rec.running && rec.status_addr == '0 && rec.blocks_ready == 8'd0)
    else $error("start did not reset the acquisition state");
`endif

endmodule
